/* hw/rtl/jfji_pkg.sv */
`timescale 1ns / 1ps
package jfji_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int PEND_DEPTH  = FRAME_BYTES - 1;
  localparam int PEND_IDX_W  = $clog2(PEND_DEPTH);
  localparam int BPOS_W      = $clog2(FRAME_BYTES + 1);
  localparam int NUM_FLAGS   = 5;
  localparam int NUM_AXES    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 1'd1;

  localparam logic [7:0]  DEAD_ZONE_RST = 8'd13;
  localparam logic [15:0] STEP_GAIN_RST = 16'd256;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int BYTE_MODE   = 0;
  localparam int BYTE_RESET  = 1;
  localparam int BYTE_SUCK   = 2;
  localparam int BYTE_JOY_X  = 3;
  localparam int BYTE_JOY_Y  = 4;
  localparam int BYTE_JOY_Z  = 5;
  localparam int BYTE_COLOUR = 6;
  localparam int BYTE_START  = 7;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef logic signed [9:0]  joy_t;
  typedef logic signed [16:0] pos_t;
  typedef logic signed [18:0] wide_t;

  localparam wide_t X_MIN = 19'sd12510;
  localparam wide_t X_MAX = 19'sd33880;
  localparam wide_t Y_MIN = -19'sd16940;
  localparam wide_t Y_MAX = 19'sd16940;
  localparam wide_t Z_MIN = 19'sd5210;
  localparam wide_t Z_MAX = 19'sd26430;

  localparam pos_t X_RST = 17'sd23195;
  localparam pos_t Y_RST = 17'sd0;
  localparam pos_t Z_RST = 17'sd15820;

  typedef enum logic [1:0] {
    FS_NONE = 2'd0,
    FS_GOOD = 2'd1,
    FS_BAD  = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [15:0]        x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        z_pos;
    logic [7:0]         op_mode;
    logic [7:0]         reset_request;
    logic [7:0]         vacuum_cmd;
    logic [7:0]         color_check;
    logic [7:0]         scan_start;
    frame_status_t      frame_status;
  } res_t;

endpackage

/* hw/rtl/jfji_if.sv */
`timescale 1ns / 1ps
interface jfji_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output func, output data_byte, output frame_start,
                  input ready);
  modport sink (input valid, input func, input data_byte, input frame_start,
                output ready);
endinterface

interface jfji_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        x_pos;
  logic signed [15:0] y_pos;
  logic [14:0]        z_pos;
  logic [7:0]         op_mode;
  logic [7:0]         reset_request;
  logic [7:0]         vacuum_cmd;
  logic [7:0]         color_check;
  logic [7:0]         scan_start;
  logic [1:0]         frame_status;

  modport source (output valid, output x_pos, output y_pos, output z_pos,
                  output op_mode, output reset_request, output vacuum_cmd,
                  output color_check, output scan_start, output frame_status,
                  input ready);
  modport sink (input valid, input x_pos, input y_pos, input z_pos,
                input op_mode, input reset_request, input vacuum_cmd,
                input color_check, input scan_start, input frame_status,
                output ready);
endinterface

/* hw/rtl/joystick_frame_jog_integrator_core.sv */
`timescale 1ns / 1ps
// Joystick frame jog integrator.
// in_ch carries one item per transfer: a frame byte (func 0, frame_start marks
// byte 0) or a control tick (func 1). Nine-byte frames are checked by XOR of
// bytes 0..7 against byte 8; a good frame latches five flag bytes and three
// joystick axes. Each tick moves the x, y, z targets by the live axes scaled
// by step_gain and clamps them to the fixed travel limits.
// out_ch gives exactly one result per input transfer: the three targets, the
// latched flags and the frame status of that item.
// The result is registered. Throughput is one item per cycle while the skid
// register is empty; the frame check and the multiply, subtract and clamp of
// each axis are combinational logic ahead of the result register.
// A stalled receiver holds the output register; one more item is taken into a
// skid register, and in_ch.ready drops only while that register is full.
// cfg_we writes dead_zone (index 0) or step_gain (index 1) from cfg_data; write
// only while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults, waits for a
// frame start, clears the latched bytes and axes, centers the targets and
// empties the output stages.
module joystick_frame_jog_integrator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jfji_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jfji_pkg::CFG_DATA_W-1:0]     cfg_data,
  jfji_in_if.sink                             in_ch,
  jfji_out_if.source                          out_ch
);
  import jfji_pkg::*;

  logic [7:0]               dead_zone_r;
  logic [15:0]              step_gain_r;
  logic [BPOS_W-1:0]        byte_pos_r, byte_pos_nxt;
  logic [7:0]               xor_r, xor_nxt;
  logic [7:0]               pend_r [PEND_DEPTH];
  joy_t                     joy_r [NUM_AXES];
  joy_t                     joy_nxt [NUM_AXES];
  logic [7:0]               flags_r [NUM_FLAGS];
  logic [7:0]               flags_nxt [NUM_FLAGS];
  pos_t                     pos_r [NUM_AXES];
  pos_t                     pos_nxt [NUM_AXES];
  logic [BPOS_W-1:0]        pos_eff;
  logic [7:0]               xor_base;
  logic                     pend_we;
  frame_status_t            status;
  res_t                     res;
  res_t                     out_r, skid_r;
  logic                     out_valid_r, skid_valid_r;
  logic                     in_fire, out_fire;

  function automatic joy_t to_axis(logic [7:0] b);
    logic [9:0] t;
    t = {1'b0, b, 1'b0} - 10'd255;
    to_axis = $signed(t);
  endfunction

  function automatic pos_t jog(pos_t pos, joy_t joy, logic [7:0] dz, logic [15:0] gain,
                               wide_t lo, wide_t hi);
    joy_t               neg;
    logic [8:0]         mag;
    joy_t               live;
    logic signed [25:0] prod;
    logic signed [17:0] q;
    wide_t              sum;
    neg  = -joy;
    mag  = joy[9] ? neg[8:0] : joy[8:0];
    live = (mag < {1'b0, dz}) ? '0 : joy;
    prod = 26'(live) * 26'($signed({1'b0, gain}));
    q    = prod[25:8];
    sum  = wide_t'(pos) - wide_t'(q);
    if (sum < lo) begin
      jog = lo[16:0];
    end else if (sum > hi) begin
      jog = hi[16:0];
    end else begin
      jog = sum[16:0];
    end
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign in_ch.ready  = !skid_valid_r;

  always_comb begin
    pos_eff      = in_ch.frame_start ? '0 : byte_pos_r;
    xor_base     = (pos_eff == '0) ? '0 : xor_r;
    byte_pos_nxt = byte_pos_r;
    xor_nxt      = xor_r;
    joy_nxt      = joy_r;
    flags_nxt    = flags_r;
    pos_nxt      = pos_r;
    pend_we      = 1'b0;
    status       = FS_NONE;
    if (in_ch.func == FUNC_BYTE) begin
      byte_pos_nxt = pos_eff;
      if (pos_eff < BPOS_W'(PEND_DEPTH)) begin
        pend_we      = 1'b1;
        xor_nxt      = xor_base ^ in_ch.data_byte;
        byte_pos_nxt = pos_eff + BPOS_W'(1);
      end else if (pos_eff == BPOS_W'(PEND_DEPTH)) begin
        if (xor_base == in_ch.data_byte) begin
          flags_nxt[0]     = pend_r[BYTE_MODE];
          flags_nxt[1]     = pend_r[BYTE_RESET];
          flags_nxt[2]     = pend_r[BYTE_SUCK];
          flags_nxt[3]     = pend_r[BYTE_COLOUR];
          flags_nxt[4]     = pend_r[BYTE_START];
          joy_nxt[AXIS_X]  = to_axis(pend_r[BYTE_JOY_X]);
          joy_nxt[AXIS_Y]  = to_axis(pend_r[BYTE_JOY_Y]);
          joy_nxt[AXIS_Z]  = to_axis(pend_r[BYTE_JOY_Z]);
          status           = FS_GOOD;
        end else begin
          status = FS_BAD;
        end
        byte_pos_nxt = BPOS_W'(FRAME_BYTES);
      end
    end else begin
      pos_nxt[AXIS_X] = jog(pos_r[AXIS_X], joy_r[AXIS_Y], dead_zone_r, step_gain_r,
                            X_MIN, X_MAX);
      pos_nxt[AXIS_Y] = jog(pos_r[AXIS_Y], joy_r[AXIS_X], dead_zone_r, step_gain_r,
                            Y_MIN, Y_MAX);
      pos_nxt[AXIS_Z] = jog(pos_r[AXIS_Z], joy_r[AXIS_Z], dead_zone_r, step_gain_r,
                            Z_MIN, Z_MAX);
    end
    res.x_pos         = pos_nxt[AXIS_X][15:0];
    res.y_pos         = pos_nxt[AXIS_Y][15:0];
    res.z_pos         = pos_nxt[AXIS_Z][14:0];
    res.op_mode       = flags_nxt[0];
    res.reset_request = flags_nxt[1];
    res.vacuum_cmd    = flags_nxt[2];
    res.color_check   = flags_nxt[3];
    res.scan_start    = flags_nxt[4];
    res.frame_status  = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DEAD_ZONE_RST;
      step_gain_r <= STEP_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE: dead_zone_r <= cfg_data[7:0];
        CFG_STEP_GAIN: step_gain_r <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= BPOS_W'(FRAME_BYTES);
      xor_r      <= '0;
      for (int i = 0; i < NUM_AXES; i++) joy_r[i] <= '0;
      for (int i = 0; i < NUM_FLAGS; i++) flags_r[i] <= '0;
      pos_r[AXIS_X] <= X_RST;
      pos_r[AXIS_Y] <= Y_RST;
      pos_r[AXIS_Z] <= Z_RST;
    end else if (in_fire) begin
      byte_pos_r <= byte_pos_nxt;
      xor_r      <= xor_nxt;
      joy_r      <= joy_nxt;
      flags_r    <= flags_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && pend_we) begin
      pend_r[pos_eff[PEND_IDX_W-1:0]] <= in_ch.data_byte;
    end
  end

  // hold the output on stall, park one more transfer in the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_ch.ready) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.x_pos         = out_r.x_pos;
  assign out_ch.y_pos         = out_r.y_pos;
  assign out_ch.z_pos         = out_r.z_pos;
  assign out_ch.op_mode       = out_r.op_mode;
  assign out_ch.reset_request = out_r.reset_request;
  assign out_ch.vacuum_cmd    = out_r.vacuum_cmd;
  assign out_ch.color_check   = out_r.color_check;
  assign out_ch.scan_start    = out_r.scan_start;
  assign out_ch.frame_status  = out_r.frame_status;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed or dropped");

  a_bpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= BPOS_W'(FRAME_BYTES))
    else $error("byte position out of range");

  a_x_limits: assert property (@(posedge clk) disable iff (!rst_n)
    wide_t'(pos_r[AXIS_X]) >= X_MIN && wide_t'(pos_r[AXIS_X]) <= X_MAX)
    else $error("x target outside travel limits");

  a_good_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && status == FS_GOOD |=> flags_r[0] == $past(pend_r[BYTE_MODE]))
    else $error("good frame did not latch the mode byte");
`endif

endmodule
